/* rtl/wdi_pkg.sv */
// wdi_pkg: shared types and constants for the weighted donor interpolation core.
// No dependencies.

package wdi_pkg;

  localparam int NODES_MAX_DEF = 4096;
  localparam int VARS_MAX_DEF  = 8;

  localparam int VAL_W  = 32;
  localparam int WGT_W  = 18;
  localparam int PROD_W = VAL_W + WGT_W;
  localparam int FRAC_W = 16;
  localparam int TERM_W = PROD_W - FRAC_W;
  localparam int ACC_W  = 48;
  localparam int NODE_W = 12;
  localparam int VIDX_W = 3;
  localparam int NV_W   = 4;
  localparam int NN_W   = 13;
  localparam int ADDR_W = 17;
  localparam int CFGD_W = 13;
  localparam int CFGI_W = 2;
  localparam int PROC_W = 16;
  localparam int PNT_W  = 31;
  localparam int BLK_W  = 16;

  localparam logic [NN_W-1:0] NUM_NODES_RST = NN_W'(4096);
  localparam logic [NV_W-1:0] NUM_VARS_RST  = NV_W'(1);

  localparam logic LAYOUT_ROW    = 1'b0;
  localparam logic LAYOUT_COLUMN = 1'b1;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_TERM  = 1'b1;

  typedef enum logic [CFGI_W-1:0] {
    CFG_NUM_VARS  = 2'd0,
    CFG_LAYOUT    = 2'd1,
    CFG_NUM_NODES = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_ISSUE,
    ST_DRAIN,
    ST_EMIT
  } wdi_state_t;

  typedef struct packed {
    logic              wr;
    logic [ADDR_W-1:0] addr;
  } wdi_store_req_t;

endpackage

/* rtl/wdi_store.sv */
// wdi_store: solution store, one write and one registered read a cycle.
// Addresses at or beyond the depth are dropped on write and flagged on read.
// Depends on wdi_pkg.

module wdi_store
  import wdi_pkg::*;
#(
  parameter int NODES_MAX = NODES_MAX_DEF,
  parameter int VARS_MAX  = VARS_MAX_DEF
) (
  input  logic                    clk,
  input  wdi_store_req_t          req,
  input  logic signed [VAL_W-1:0] wdata,
  output logic signed [VAL_W-1:0] rdata,
  output logic                    rd_ok
);

  localparam int DEPTH = NODES_MAX * VARS_MAX;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = (ADDR_W > IDX_W) ? ADDR_W + 1 : IDX_W + 1;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

  logic signed [VAL_W-1:0] mem [DEPTH];
  logic [CMP_W-1:0]        addr_ext;
  logic [IDX_W-1:0]        idx;
  logic                    in_range;
  logic signed [VAL_W-1:0] rdata_r;
  logic                    rd_ok_r;

  assign addr_ext = CMP_W'(req.addr);
  assign idx      = addr_ext[IDX_W-1:0];
  assign in_range = addr_ext < DEPTH_C;

  always_ff @(posedge clk) begin
    if (req.wr && in_range) begin
      mem[idx] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[idx];
    rd_ok_r <= in_range;
  end

  assign rdata = rdata_r;
  assign rd_ok = rd_ok_r;

endmodule

/* rtl/wdi_mac.sv */
// wdi_mac: registered value-by-weight product, floored to a Q18.16 term.
// Depends on wdi_pkg.

module wdi_mac
  import wdi_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic                     ok,
  input  logic signed [VAL_W-1:0]  value,
  input  logic signed [WGT_W-1:0]  weight,
  output logic signed [TERM_W-1:0] term
);

  logic signed [PROD_W-1:0] product_r;
  logic signed [PROD_W-1:0] product_shr;

  always_ff @(posedge clk) begin
    if (en) begin
      product_r <= ok ? PROD_W'(value * weight) : '0;
    end
  end

  // arithmetic shift gives floor rounding
  assign product_shr = product_r >>> FRAC_W;
  assign term        = product_shr[TERM_W-1:0];

endmodule

/* rtl/weighted_donor_interpolation_core.sv */
// Weighted donor interpolation core: sparse weighted gather-sum over a solution store.
// Donor term: nv variables through one store read port and one shared multiplier; the
// last term then emits nv results, one a cycle unless the output stalls. Results leave
// through an output register.
// Reset (rst_n, synchronous): config to num_vars 1, row layout, 4096 nodes;
// accumulators zero; store contents undefined until written, no clearing pass.

module weighted_donor_interpolation_core
  import wdi_pkg::*;
#(
  parameter int NODES_MAX = NODES_MAX_DEF,
  parameter int VARS_MAX  = VARS_MAX_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFGI_W-1:0]        cfg_index,
  input  logic [CFGD_W-1:0]        cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_action,
  input  logic [NODE_W-1:0]        in_node_index,
  input  logic [VIDX_W-1:0]        in_var_index,
  input  logic signed [VAL_W-1:0]  in_write_value,
  input  logic signed [WGT_W-1:0]  in_weight,
  input  logic                     in_last_term,
  input  logic                     in_skip_receptor,
  input  logic [PROC_W-1:0]        in_receptor_proc,
  input  logic [PNT_W-1:0]         in_receptor_point,
  input  logic [BLK_W-1:0]         in_receptor_block,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [PROC_W-1:0]        out_receptor_proc,
  output logic [PNT_W-1:0]         out_receptor_point,
  output logic [BLK_W-1:0]         out_receptor_block,
  output logic [VIDX_W-1:0]        out_var_index,
  output logic signed [VAL_W-1:0]  out_value,
  output logic                     out_is_last_var
);

  localparam int AIW = (VARS_MAX > 1) ? $clog2(VARS_MAX) : 1;
  localparam logic signed [ACC_W:0] ACC_HI = (ACC_W+1)'(2 ** (ACC_W - 1) - 1);
  localparam logic signed [ACC_W:0] ACC_LO = -ACC_HI - (ACC_W+1)'(1);
  localparam logic signed [ACC_W-1:0] OUT_HI = ACC_W'(2 ** (VAL_W - 1) - 1);
  localparam logic signed [ACC_W-1:0] OUT_LO = -OUT_HI - ACC_W'(1);

  wdi_state_t state_r, state_nxt;

  logic [NV_W-1:0]   num_vars_r;
  logic              layout_r;
  logic [NN_W-1:0]   num_nodes_r;

  logic [NV_W-1:0]   nv_c;
  logic [NV_W-1:0]   nv_r;
  logic [VIDX_W-1:0] var_sel;
  logic [ADDR_W-1:0] a_row, a_col;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] stride_r;
  logic              wr_ok_r;
  logic signed [VAL_W-1:0] wdata_r;
  logic signed [WGT_W-1:0] weight_r;
  logic              last_r;
  logic [PROC_W-1:0] proc_r;
  logic [PNT_W-1:0]  point_r;
  logic [BLK_W-1:0]  block_r;

  logic [NV_W-1:0]   kiss_r;
  logic [NV_W-1:0]   ek_r;
  logic              p1_v_r, p2_v_r;
  logic [NV_W-1:0]   p1_k_r, p2_k_r;

  logic signed [ACC_W-1:0] acc_r [VARS_MAX];

  logic              accept;
  logic              issue;
  logic              issue_last;
  logic              emit_load;
  logic              emit_last;
  logic              acc_clear;
  logic              out_free;

  wdi_store_req_t          st_req;
  logic signed [VAL_W-1:0] st_rdata;
  logic                    st_ok;
  logic signed [TERM_W-1:0] term;

  logic signed [ACC_W:0]   acc_sum;
  logic signed [ACC_W-1:0] acc_sat;
  logic signed [ACC_W-1:0] emit_acc;
  logic signed [VAL_W-1:0] emit_val;

  logic              out_valid_r;
  logic [PROC_W-1:0] out_proc_r;
  logic [PNT_W-1:0]  out_point_r;
  logic [BLK_W-1:0]  out_block_r;
  logic [VIDX_W-1:0] out_var_r;
  logic signed [VAL_W-1:0] out_value_r;
  logic              out_last_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_vars_r  <= NUM_VARS_RST;
      layout_r    <= LAYOUT_ROW;
      num_nodes_r <= NUM_NODES_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_NUM_VARS:  num_vars_r  <= cfg_wdata[NV_W-1:0];
        CFG_LAYOUT:    layout_r    <= cfg_wdata[0];
        CFG_NUM_NODES: num_nodes_r <= cfg_wdata[NN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (num_vars_r == '0) begin
      nv_c = NV_W'(1);
    end else if ({1'b0, num_vars_r} > (NV_W+1)'(VARS_MAX)) begin
      nv_c = NV_W'(VARS_MAX);
    end else begin
      nv_c = num_vars_r;
    end
  end

  // start address; a donor term starts at variable zero
  assign var_sel = (in_action == ACT_TERM) ? '0 : in_var_index;
  assign a_row   = ADDR_W'(in_node_index) * ADDR_W'(nv_c) + ADDR_W'(var_sel);
  assign a_col   = ADDR_W'(var_sel) * ADDR_W'(num_nodes_r) + ADDR_W'(in_node_index);

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    issue      = 1'b0;
    issue_last = 1'b0;
    emit_load  = 1'b0;
    emit_last  = (ek_r == nv_r - NV_W'(1));
    acc_clear  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_action == ACT_WRITE) begin
            state_nxt = ST_WRITE;
          end else if (in_skip_receptor) begin
            acc_clear = in_last_term;
          end else begin
            state_nxt = ST_ISSUE;
          end
        end
      end
      ST_WRITE: state_nxt = ST_IDLE;
      ST_ISSUE: begin
        issue      = 1'b1;
        issue_last = (kiss_r == nv_r - NV_W'(1));
        if (issue_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!p1_v_r && !p2_v_r) begin
          state_nxt = last_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          emit_load = 1'b1;
          if (emit_last) begin
            acc_clear = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kiss_r <= '0;
      ek_r   <= '0;
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
    end else begin
      p1_v_r <= issue;
      p2_v_r <= p1_v_r;
      if (accept) begin
        kiss_r <= '0;
        ek_r   <= '0;
      end else begin
        if (issue) kiss_r <= kiss_r + NV_W'(1);
        if (emit_load) ek_r <= ek_r + NV_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    p1_k_r <= kiss_r;
    p2_k_r <= p1_k_r;
    if (accept) begin
      nv_r     <= nv_c;
      addr_r   <= (layout_r == LAYOUT_COLUMN) ? a_col : a_row;
      stride_r <= (layout_r == LAYOUT_COLUMN) ? ADDR_W'(num_nodes_r) : ADDR_W'(1);
      wr_ok_r  <= ({1'b0, in_var_index} < nv_c);
      wdata_r  <= in_write_value;
      weight_r <= in_weight;
      last_r   <= in_last_term;
      proc_r   <= in_receptor_proc;
      point_r  <= in_receptor_point;
      block_r  <= in_receptor_block;
    end else if (issue) begin
      addr_r <= addr_r + stride_r;
    end
  end

  assign st_req.wr   = (state_r == ST_WRITE) && wr_ok_r;
  assign st_req.addr = addr_r;

  wdi_store #(
    .NODES_MAX (NODES_MAX),
    .VARS_MAX  (VARS_MAX)
  ) u_store (
    .clk   (clk),
    .req   (st_req),
    .wdata (wdata_r),
    .rdata (st_rdata),
    .rd_ok (st_ok)
  );

  wdi_mac u_mac (
    .clk    (clk),
    .en     (p1_v_r),
    .ok     (st_ok),
    .value  (st_rdata),
    .weight (weight_r),
    .term   (term)
  );

  // saturating accumulate
  assign acc_sum = (ACC_W+1)'(acc_r[p2_k_r[AIW-1:0]]) + (ACC_W+1)'(term);

  always_comb begin
    if (acc_sum > ACC_HI) begin
      acc_sat = ACC_HI[ACC_W-1:0];
    end else if (acc_sum < ACC_LO) begin
      acc_sat = ACC_LO[ACC_W-1:0];
    end else begin
      acc_sat = acc_sum[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || acc_clear) begin
      for (int i = 0; i < VARS_MAX; i++) begin
        acc_r[i] <= '0;
      end
    end else if (p2_v_r) begin
      acc_r[p2_k_r[AIW-1:0]] <= acc_sat;
    end
  end

  assign emit_acc = acc_r[ek_r[AIW-1:0]];

  always_comb begin
    if (emit_acc > OUT_HI) begin
      emit_val = OUT_HI[VAL_W-1:0];
    end else if (emit_acc < OUT_LO) begin
      emit_val = OUT_LO[VAL_W-1:0];
    end else begin
      emit_val = emit_acc[VAL_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_proc_r  <= proc_r;
      out_point_r <= point_r;
      out_block_r <= block_r;
      out_var_r   <= ek_r[VIDX_W-1:0];
      out_value_r <= emit_val;
      out_last_r  <= emit_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_receptor_proc  = out_proc_r;
  assign out_receptor_point = out_point_r;
  assign out_receptor_block = out_block_r;
  assign out_var_index      = out_var_r;
  assign out_value          = out_value_r;
  assign out_is_last_var    = out_last_r;

endmodule

/* rtl/wdi_checker.sv */
// wdi_checker: port-level checks on the weighted donor interpolation core, and its bind.
// Depends on wdi_pkg and weighted_donor_interpolation_core.

module wdi_checker
  import wdi_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              in_action,
  input logic              in_skip_receptor,
  input logic              out_valid,
  input logic              out_stall,
  input logic [VIDX_W-1:0] out_var_index,
  input logic              out_is_last_var
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && ((in_action == ACT_WRITE) || !in_skip_receptor) |=> in_stall)
    else $error("request taken while previous one still in progress");

  a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_last_var |-> in_stall)
    else $error("request side free before run of results ends");

  a_run_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_is_last_var |=>
      out_valid && (out_var_index == $past(out_var_index) + VIDX_W'(1)))
    else $error("results of a run not back to back in variable order");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind weighted_donor_interpolation_core wdi_checker u_wdi_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_action        (in_action),
  .in_skip_receptor (in_skip_receptor),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_var_index    (out_var_index),
  .out_is_last_var  (out_is_last_var)
);

/* bench/tb_weighted_donor_interpolation_core.sv */
// Self-checking bench for weighted_donor_interpolation_core: a queue-fed driver, a monitor
// and a request-level interpolation model covering layouts, saturation, cancelled receptors.
// Depends on rtl/wdi_pkg.sv and rtl/weighted_donor_interpolation_core.sv.
`timescale 1ns / 1ps

module tb_weighted_donor_interpolation_core;
  import wdi_pkg::*;

  localparam int STORE_DEPTH = NODES_MAX_DEF * VARS_MAX_DEF;
  localparam int ITEMS_PER_PHASE = 62;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam longint OUT_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam longint OUT_LO = -OUT_HI - 1;

  typedef struct {
    logic                     action;
    logic [NODE_W-1:0]        node;
    logic [VIDX_W-1:0]        var_idx;
    logic signed [VAL_W-1:0]  value;
    logic signed [WGT_W-1:0]  weight;
    logic                     last;
    logic                     skip;
    logic [PROC_W-1:0]        proc;
    logic [PNT_W-1:0]         point;
    logic [BLK_W-1:0]         blk;
  } interp_req_t;

  typedef struct {
    logic [PROC_W-1:0]        proc;
    logic [PNT_W-1:0]         point;
    logic [BLK_W-1:0]         blk;
    logic [VIDX_W-1:0]        var_idx;
    logic [VAL_W-1:0]         value;
    logic                     last_var;
  } interp_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFGI_W-1:0]       cfg_index = '0;
  logic [CFGD_W-1:0]       cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    in_action = 1'b0;
  logic [NODE_W-1:0]       in_node_index = '0;
  logic [VIDX_W-1:0]       in_var_index = '0;
  logic signed [VAL_W-1:0] in_write_value = '0;
  logic signed [WGT_W-1:0] in_weight = '0;
  logic                    in_last_term = 1'b0;
  logic                    in_skip_receptor = 1'b0;
  logic [PROC_W-1:0]       in_receptor_proc = '0;
  logic [PNT_W-1:0]        in_receptor_point = '0;
  logic [BLK_W-1:0]        in_receptor_block = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [PROC_W-1:0]       out_receptor_proc;
  logic [PNT_W-1:0]        out_receptor_point;
  logic [BLK_W-1:0]        out_receptor_block;
  logic [VIDX_W-1:0]       out_var_index;
  logic signed [VAL_W-1:0] out_value;
  logic                    out_is_last_var;

  // model state
  logic signed [VAL_W-1:0] solution_copy [STORE_DEPTH];
  bit                      store_written [STORE_DEPTH];
  longint                  var_acc [VARS_MAX_DEF];
  logic [NV_W-1:0]         vars_cfg = NUM_VARS_RST;
  logic                    layout_cfg = LAYOUT_ROW;
  logic [NN_W-1:0]         nodes_cfg = NUM_NODES_RST;

  interp_req_t             pending_requests [$];
  interp_result_t          expected_values [$];
  interp_req_t             cur_req;
  interp_result_t          want;
  int unsigned             tx_idle_pct = 28;
  int unsigned             rx_idle_pct = 70;
  int unsigned             mismatches = 0;
  int unsigned             cycle_count = 0;

  int unsigned phase_vars [6] = '{3, 8, 1, 15, 0, 8};
  logic        phase_layout [6] = '{LAYOUT_ROW, LAYOUT_COLUMN, LAYOUT_COLUMN,
                                    LAYOUT_COLUMN, LAYOUT_COLUMN, LAYOUT_ROW};
  int unsigned phase_nodes [6] = '{4096, 4096, 1, 8191, 0, 13};

  weighted_donor_interpolation_core u_top (.*);

  always #5 clk = ~clk;

  function automatic int unsigned eff_vars();
    if (vars_cfg == 0) return 1;
    if (vars_cfg > VARS_MAX_DEF) return VARS_MAX_DEF;
    return vars_cfg;
  endfunction

  function automatic longint store_addr(input logic [NODE_W-1:0] node, input int unsigned vi);
    if (layout_cfg == LAYOUT_COLUMN) return longint'(vi) * longint'(nodes_cfg) + longint'(node);
    return longint'(node) * longint'(eff_vars()) + longint'(vi);
  endfunction

  function automatic void interpolate(input interp_req_t r);
    int unsigned nv;
    longint a;
    longint v;
    longint w;
    longint s;
    interp_result_t res;
    nv = eff_vars();
    if (r.action == ACT_WRITE) begin
      a = store_addr(r.node, r.var_idx);
      if (r.var_idx < nv && a < STORE_DEPTH) solution_copy[a] = r.value;
      return;
    end
    if (r.skip) begin
      if (r.last) foreach (var_acc[i]) var_acc[i] = 0;
      return;
    end
    w = r.weight;
    for (int k = 0; k < nv; k++) begin
      a = store_addr(r.node, k);
      v = 0;
      if (a < STORE_DEPTH) v = solution_copy[a];
      s = var_acc[k] + ((v * w) >>> FRAC_W);
      if (s > ACC_HI) s = ACC_HI;
      else if (s < ACC_LO) s = ACC_LO;
      var_acc[k] = s;
    end
    if (!r.last) return;
    for (int k = 0; k < nv; k++) begin
      s = var_acc[k];
      if (s > OUT_HI) s = OUT_HI;
      else if (s < OUT_LO) s = OUT_LO;
      res.proc = r.proc;
      res.point = r.point;
      res.blk = r.blk;
      res.var_idx = VIDX_W'(k);
      res.value = s[VAL_W-1:0];
      res.last_var = (k == nv - 1);
      expected_values.push_back(res);
    end
    foreach (var_acc[i]) var_acc[i] = 0;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  function automatic interp_req_t rand_req();
    interp_req_t r;
    r.action = 1'($urandom);
    r.node = NODE_W'($urandom);
    r.var_idx = VIDX_W'($urandom);
    r.value = VAL_W'($urandom);
    r.weight = WGT_W'($urandom);
    r.last = 1'($urandom);
    r.skip = 1'($urandom);
    r.proc = PROC_W'($urandom);
    r.point = PNT_W'($urandom);
    r.blk = BLK_W'($urandom);
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(7))
      0, 1: return $urandom;
      2: return ($urandom_range(1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      3: return ($urandom_range(1) != 0) ? '1 : '0;
      default: return VAL_W'($urandom_range(32'h1F_FFFF) - 32'h10_0000);
    endcase
  endfunction

  function automatic logic [WGT_W-1:0] rand_weight();
    case ($urandom_range(7))
      0: return WGT_W'($urandom);
      1: return ($urandom_range(1) != 0) ? 18'h1FFFF : 18'h20000;
      2: return ($urandom_range(1) != 0) ? 18'h10000 : 18'h30000;
      default: return WGT_W'($urandom_range(18'h1FFFF) - 18'h10000);
    endcase
  endfunction

  function automatic logic [NODE_W-1:0] pick_node();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return NODE_W'($urandom_range(15));
      6, 7: return NODE_W'(4080 + $urandom_range(15));
      default: return NODE_W'($urandom_range(4095));
    endcase
  endfunction

  function automatic void queue_write(input logic [NODE_W-1:0] node, input int unsigned vi,
                                     input logic [VAL_W-1:0] val);
    interp_req_t r;
    longint a;
    r = rand_req();
    r.action = ACT_WRITE;
    r.node = node;
    r.var_idx = VIDX_W'(vi);
    r.value = val;
    a = store_addr(node, vi);
    if (vi < eff_vars() && a < STORE_DEPTH) store_written[a] = 1'b1;
    pending_requests.push_back(r);
  endfunction

  function automatic interp_req_t term_req(input logic [NODE_W-1:0] node,
                                          input logic [WGT_W-1:0] weight,
                                          input logic last, input logic skip);
    interp_req_t r;
    r = rand_req();
    r.action = ACT_TERM;
    r.node = node;
    r.weight = weight;
    r.last = last;
    r.skip = skip;
    return r;
  endfunction

  // donors are never read before every in-range entry of theirs is written
  function automatic void ensure_written(input logic [NODE_W-1:0] node);
    longint a;
    for (int k = 0; k < eff_vars(); k++) begin
      a = store_addr(node, k);
      if (a < STORE_DEPTH && !store_written[a]) queue_write(node, k, rand_value());
    end
  endfunction

  function automatic void gen_receptor();
    int unsigned terms;
    logic cancelled;
    logic skip;
    logic [NODE_W-1:0] node;
    terms = $urandom_range(1, 4);
    cancelled = ($urandom_range(9) == 0);
    for (int t = 0; t < terms; t++) begin
      node = pick_node();
      skip = cancelled && (t == terms - 1);
      if (!skip) ensure_written(node);
      if ($urandom_range(7) == 0) begin
        if ($urandom_range(1) != 0)
          queue_write(NODE_W'($urandom_range(4095)), $urandom_range(7), rand_value());
        else
          pending_requests.push_back(term_req(pick_node(), rand_weight(), 1'b0, 1'b1));
      end
      pending_requests.push_back(term_req(node, rand_weight(), t == terms - 1, skip));
    end
  endfunction

  task automatic write_cfg(input cfg_reg_t idx, input logic [CFGD_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_NUM_VARS: vars_cfg = val[NV_W-1:0];
      CFG_LAYOUT: layout_cfg = val[0];
      CFG_NUM_NODES: nodes_cfg = val[NN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_requests.size() != 0 || in_valid || expected_values.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) interpolate(cur_req);
      if (!in_valid || !in_stall) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          cur_req = pending_requests.pop_front();
          in_valid <= 1'b1;
          in_action <= cur_req.action;
          in_node_index <= cur_req.node;
          in_var_index <= cur_req.var_idx;
          in_write_value <= cur_req.value;
          in_weight <= cur_req.weight;
          in_last_term <= cur_req.last;
          in_skip_receptor <= cur_req.skip;
          in_receptor_proc <= cur_req.proc;
          in_receptor_point <= cur_req.point;
          in_receptor_block <= cur_req.blk;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_values.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual var %0d value %h",
                   $time, out_var_index, out_value);
          mismatches++;
        end else begin
          want = expected_values.pop_front();
          check_field("receptor_proc", want.proc, out_receptor_proc);
          check_field("receptor_point", want.point, out_receptor_point);
          check_field("receptor_block", want.blk, out_receptor_block);
          check_field("var_index", want.var_idx, out_var_index);
          check_field("value", want.value, out_value);
          check_field("is_last_var", want.last_var, out_is_last_var);
        end
      end
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    interp_req_t r;
    foreach (var_acc[i]) var_acc[i] = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset configuration: one variable, row layout
    @(negedge clk);
    queue_write(0, 0, 32'h7FFF_FFFF);
    queue_write(4095, 0, 32'h8000_0000);
    queue_write(1, 7, 32'h1234_5678);
    queue_write(1, 0, 32'h0001_0000);
    pending_requests.push_back(term_req(0, 18'h1FFFF, 1'b0, 1'b0));
    r = term_req(4095, 18'h20000, 1'b1, 1'b0);
    r.proc = '1;
    r.point = '1;
    r.blk = '1;
    pending_requests.push_back(r);
    r = term_req(4095, 18'h1FFFF, 1'b1, 1'b0);
    r.proc = '0;
    r.point = '0;
    r.blk = '0;
    pending_requests.push_back(r);
    pending_requests.push_back(term_req(1, 18'h10000, 1'b0, 1'b0));
    pending_requests.push_back(term_req(1, 18'h3FFFF, 1'b0, 1'b1));
    queue_write(1, 0, 32'h0002_0000);
    pending_requests.push_back(term_req(1, 18'h3FFFF, 1'b1, 1'b0));
    pending_requests.push_back(term_req(0, 18'd100, 1'b0, 1'b0));
    pending_requests.push_back(term_req(0, 18'h00000, 1'b1, 1'b1));
    pending_requests.push_back(term_req(1, 18'h10000, 1'b1, 1'b0));
    pending_requests.push_back(term_req(0, 18'h00000, 1'b1, 1'b0));
    pending_requests.push_back(term_req(0, 18'h3FFFF, 1'b1, 1'b0));
    pending_requests.push_back(term_req(4095, 18'h3FFFF, 1'b1, 1'b0));
    queue_write(4095, 0, 32'hFFFF_FFFF);
    pending_requests.push_back(term_req(4095, 18'h00001, 1'b1, 1'b0));
    drain();

    for (int p = 0; p < 6; p++) begin
      write_cfg(CFG_NUM_VARS, CFGD_W'(phase_vars[p]));
      write_cfg(CFG_LAYOUT, CFGD_W'(phase_layout[p]));
      write_cfg(CFG_NUM_NODES, CFGD_W'(phase_nodes[p]));
      @(negedge clk);
      tx_idle_pct = (p < 2) ? 28 : (p < 4) ? 70 : 0;
      rx_idle_pct = (p < 2) ? 70 : (p < 4) ? 28 : 0;
      while (pending_requests.size() < ITEMS_PER_PHASE) gen_receptor();
      drain();
    end

    if (mismatches == 0 && expected_values.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/wdi_pkg.sv
rtl/wdi_store.sv
rtl/wdi_mac.sv
rtl/weighted_donor_interpolation_core.sv
rtl/wdi_checker.sv
bench/tb_weighted_donor_interpolation_core.sv
